// ===== rtl/qbsd_pkg.sv =====
`timescale 1ns / 1ps

package qbsd_pkg;

    // Fixed-point formats of the item fields and the internal datapath.
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LOCAL_FRAC = 28;
    localparam int SEL_W      = 3;
    localparam int DIMS_W     = 2;
    localparam int STAT_W     = 2;
    localparam int N_NODES    = 3;
    localparam int N_AXES     = 3;
    localparam int N_LANES    = N_NODES * N_AXES;

    // Local derivative constants and their magnitudes.
    localparam int DN_W   = 31;
    localparam int DNM_W  = 30;
    // Tangent products, sums, magnitudes and normalized values.
    localparam int PROD_W  = COORD_W + DN_W;
    localparam int JT_W    = 64;
    localparam int MAG_W   = 62;
    localparam int POS_W   = 6;
    localparam int SHIFT_W = 5;
    localparam int NORM_W  = 30;
    localparam int SQ_W    = 2 * NORM_W;
    localparam int SUM_W   = 62;
    // Long division and square root.
    localparam int QUOT_W    = COORD_W + 2;
    localparam int DIV_STEPS = QUOT_W;
    localparam int NUM_W     = SQ_W + 2 * FRAC_BITS + 1;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_W    = 64;
    localparam int ROOT_W    = 31;
    localparam int DM_W      = COORD_W + 2;

    // Point selector codes.
    localparam logic [SEL_W-1:0] PT_GAUSS_NEG = 3'd0;
    localparam logic [SEL_W-1:0] PT_GAUSS_POS = 3'd1;
    localparam logic [SEL_W-1:0] PT_NODE_LO   = 3'd2;
    localparam logic [SEL_W-1:0] PT_NODE_HI   = 3'd3;
    localparam logic [SEL_W-1:0] PT_NODE_MID  = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] node0_x;
        logic signed [COORD_W-1:0] node0_y;
        logic signed [COORD_W-1:0] node0_z;
        logic signed [COORD_W-1:0] node1_x;
        logic signed [COORD_W-1:0] node1_y;
        logic signed [COORD_W-1:0] node1_z;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic        [SEL_W-1:0]   point_select;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] jac_det;
        logic signed [COORD_W-1:0] dx_node0;
        logic signed [COORD_W-1:0] dx_node1;
        logic signed [COORD_W-1:0] dx_mid;
        logic signed [COORD_W-1:0] dy_node0;
        logic signed [COORD_W-1:0] dy_node1;
        logic signed [COORD_W-1:0] dy_mid;
        logic signed [COORD_W-1:0] dz_node0;
        logic signed [COORD_W-1:0] dz_node1;
        logic signed [COORD_W-1:0] dz_mid;
        logic        [STAT_W-1:0]  status;
    } t_out_item;

    // Per-item control carried through the front stages.
    typedef struct packed {
        logic [SEL_W-1:0]   sel;
        logic [DIMS_W-1:0]  dims;
        logic [N_AXES-1:0]  jneg;
        logic               zero;
        logic [SHIFT_W-1:0] k;
        logic [DM_W-1:0]    dm1;
    } t_meta;

    // Per-item control carried alongside the divider and square root.
    typedef struct packed {
        logic               zero;
        logic [DIMS_W-1:0]  dims;
        logic [SHIFT_W-1:0] k;
        logic               neg0;
        logic [DM_W-1:0]    dm1;
        logic [N_LANES-1:0] lane_nz;
        logic [N_LANES-1:0] lane_ovf;
        logic [N_LANES-1:0] lane_neg;
    } t_side;

    // Local derivatives [r-0.5, r+0.5, -2r] in Q.28 for each point.
    function automatic logic signed [DN_W-1:0] dn_const(input logic [SEL_W-1:0] sel,
                                                        input logic [1:0] idx);
        logic signed [DN_W-1:0] v0;
        logic signed [DN_W-1:0] v1;
        logic signed [DN_W-1:0] v2;
        logic signed [DN_W-1:0] res;
        unique case (sel)
            PT_GAUSS_NEG: begin
                v0 = -31'sd289199011; v1 = -31'sd20763555;  v2 = 31'sd309962566;
            end
            PT_GAUSS_POS: begin
                v0 = 31'sd20763555;   v1 = 31'sd289199011;  v2 = -31'sd309962566;
            end
            PT_NODE_LO: begin
                v0 = -31'sd402653184; v1 = -31'sd134217728; v2 = 31'sd536870912;
            end
            PT_NODE_HI: begin
                v0 = 31'sd134217728;  v1 = 31'sd402653184;  v2 = -31'sd536870912;
            end
            default: begin
                v0 = -31'sd134217728; v1 = 31'sd134217728;  v2 = 31'sd0;
            end
        endcase
        unique case (idx)
            2'd0:    res = v0;
            2'd1:    res = v1;
            2'd2:    res = v2;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [DNM_W-1:0] dn_mag(input logic [SEL_W-1:0] sel,
                                                 input logic [1:0] idx);
        logic signed [DN_W-1:0] v;
        v = dn_const(sel, idx);
        return v[DN_W-1] ? DNM_W'(-v) : DNM_W'(v);
    endfunction

endpackage

// ===== rtl/qbsd_div_bank.sv =====
`timescale 1ns / 1ps

// Restoring long division, one quotient bit per stage, for all lanes at once.
// The lanes share one divisor, which travels down its own register line.
module qbsd_div_bank
    import qbsd_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [SUM_W-1:0]                    i_den,
    input  logic [N_LANES-1:0][SUM_W-1:0]       i_rem,
    input  logic [N_LANES-1:0][QUOT_W-1:0]      i_num,
    output logic [N_LANES-1:0][QUOT_W-1:0]      o_quot
);

    logic [SUM_W-1:0]                  r_den  [DIV_STEPS];
    logic [N_LANES-1:0][SUM_W-1:0]     r_rem  [DIV_STEPS];
    logic [N_LANES-1:0][QUOT_W-1:0]    r_word [DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_step
            logic [SUM_W-1:0]                  prev_den;
            logic [N_LANES-1:0][SUM_W-1:0]     prev_rem;
            logic [N_LANES-1:0][QUOT_W-1:0]    prev_word;
            logic [N_LANES-1:0][SUM_W-1:0]     n_rem;
            logic [N_LANES-1:0][QUOT_W-1:0]    n_word;

            if (j == 0) begin : g_first
                assign prev_den  = i_den;
                assign prev_rem  = i_rem;
                assign prev_word = i_num;
            end else begin : g_next
                assign prev_den  = r_den[j-1];
                assign prev_rem  = r_rem[j-1];
                assign prev_word = r_word[j-1];
            end

            // Bring down the next numerator bit and try one subtraction per lane.
            always_comb begin
                for (int l = 0; l < N_LANES; l++) begin
                    logic [SUM_W:0] trial;
                    logic           ge;
                    trial = {prev_rem[l], prev_word[l][QUOT_W-1]};
                    ge    = trial >= {1'b0, prev_den};
                    n_rem[l]  = ge ? SUM_W'(trial - {1'b0, prev_den}) : SUM_W'(trial);
                    n_word[l] = {prev_word[l][QUOT_W-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[j]  <= prev_den;
                    r_rem[j]  <= n_rem;
                    r_word[j] <= n_word;
                end
            end
        end
    endgenerate

    assign o_quot = r_word[DIV_STEPS-1];

endmodule

// ===== rtl/qbsd_isqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, one root bit per stage, padded to the divider latency.
module qbsd_isqrt
    import qbsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    localparam int PAD = DIV_STEPS - SQRT_STEPS;

    logic [SQRT_W-1:0] r_x [SQRT_STEPS];
    logic [SQRT_W-1:0] r_r [SQRT_STEPS];
    logic [ROOT_W-1:0] r_pad [PAD];

    genvar t;
    generate
        for (t = 0; t < SQRT_STEPS; t++) begin : g_step
            localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * t);
            logic [SQRT_W-1:0] prev_x;
            logic [SQRT_W-1:0] prev_r;
            logic [SQRT_W-1:0] n_x;
            logic [SQRT_W-1:0] n_r;

            if (t == 0) begin : g_first
                assign prev_x = SQRT_W'(i_rad);
                assign prev_r = '0;
            end else begin : g_next
                assign prev_x = r_x[t-1];
                assign prev_r = r_r[t-1];
            end

            // Accept this root bit when the remainder allows it.
            always_comb begin
                if (prev_x >= prev_r + BIT) begin
                    n_x = prev_x - (prev_r + BIT);
                    n_r = (prev_r >> 1) + BIT;
                end else begin
                    n_x = prev_x;
                    n_r = prev_r >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[t] <= n_x;
                    r_r[t] <= n_r;
                end
            end
        end

        // Delay stages that line the root up with the quotients.
        for (t = 0; t < PAD; t++) begin : g_pad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (t == 0) begin
                        r_pad[t] <= ROOT_W'(r_r[SQRT_STEPS-1]);
                    end else begin
                        r_pad[t] <= r_pad[(t == 0) ? 0 : t-1];
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_pad[PAD-1];

endmodule

// ===== rtl/quadratic_bar_shape_derivatives.sv =====
`timescale 1ns / 1ps

// Shape-function derivatives and Jacobian of a three-node quadratic bar at one
// local point per item. The block takes one item per clock unless the output
// stalls. Eight front stages form the tangent, normalize it and build the
// squared length, then 34 stages of a bit-serial divider (one quotient bit per
// stage, shared divisor for all nine derivatives) run beside a square root of
// the same depth, and a last stage rounds, saturates and registers the result.
// A stall at the output holds the whole pipeline. space_dims may only be
// written while the pipeline is empty.
module quadratic_bar_shape_derivatives
    import qbsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [DIMS_W-1:0] i_cfg_wdata
);

    typedef struct packed {
        logic                      sat;
        logic signed [COORD_W-1:0] val;
    } t_sat_val;

    localparam logic [DM_W-1:0]  POS_MAX = DM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [DM_W-1:0]  NEG_MAX = DM_W'(64'd1 << (COORD_W - 1));
    localparam logic [DM_W-1:0]  BIG_MAG = DM_W'(64'd1 << (COORD_W + 1));
    localparam logic [MAG_W:0]   LF_HALF = (MAG_W + 1)'(1) << (LOCAL_FRAC - 1);
    localparam logic [SUM_W:0]   DET_HALF = (SUM_W + 1)'(1) << (LOCAL_FRAC - 1);
    localparam logic [POS_W-1:0] NORM_TOP = POS_W'(NORM_W - 1);
    localparam logic [POS_W-1:0] DIV_SHIFT = POS_W'(2 * FRAC_BITS + 1);

    // Saturate a sign and magnitude to the output width.
    function automatic t_sat_val put_signed(input logic neg, input logic [DM_W-1:0] mag);
        t_sat_val res;
        res.sat = 1'b0;
        if (neg) begin
            if (mag > NEG_MAX) begin
                res.sat = 1'b1;
                res.val = COORD_W'(DM_W'(0) - NEG_MAX);
            end else begin
                res.val = COORD_W'(DM_W'(0) - mag);
            end
        end else begin
            if (mag > POS_MAX) begin
                res.sat = 1'b1;
                res.val = COORD_W'(POS_MAX);
            end else begin
                res.val = COORD_W'(mag);
            end
        end
        return res;
    endfunction

    logic [DIMS_W-1:0] r_space_dims;
    logic              adv;

    // Pipeline registers.
    logic                      r_vld [8];
    t_meta                     r_meta [8];
    logic signed [PROD_W-1:0]  r_s1_prod [N_NODES][N_AXES];
    logic signed [JT_W-1:0]    r_s2_jt [N_AXES];
    logic [MAG_W-1:0]          r_s3_mg [N_AXES];
    logic [MAG_W-1:0]          r_s4_mg [N_AXES];
    logic [NORM_W-1:0]         r_s5_m [N_AXES];
    logic [SQ_W-1:0]           r_s6_sq [N_AXES];
    logic [SQ_W-1:0]           r_s6_p [N_LANES];
    logic [SUM_W-1:0]          r_s7_s;
    logic [SQ_W-1:0]           r_s7_p [N_LANES];
    logic [SUM_W-1:0]          r_s8_s;
    logic [N_LANES-1:0][SUM_W-1:0]  r_s8_rem;
    logic [N_LANES-1:0][QUOT_W-1:0] r_s8_num;
    t_side                     r_s8_side;
    logic                      r_dv [DIV_STEPS];
    t_side                     r_dside [DIV_STEPS];
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    // Next values.
    t_meta                     n_meta [8];
    logic signed [PROD_W-1:0]  n_s1_prod [N_NODES][N_AXES];
    logic signed [COORD_W-1:0] coord [N_NODES][N_AXES];
    logic signed [JT_W-1:0]    n_s2_jt [N_AXES];
    logic [MAG_W-1:0]          n_s3_mg [N_AXES];
    logic [MAG_W-1:0]          or_mag;
    logic [POS_W-1:0]          msb_pos;
    logic [NORM_W-1:0]         n_s5_m [N_AXES];
    logic [SQ_W-1:0]           n_s6_sq [N_AXES];
    logic [SQ_W-1:0]           n_s6_p [N_LANES];
    logic [SUM_W-1:0]          n_s7_s;
    logic [N_LANES-1:0][SUM_W-1:0]  n_s8_rem;
    logic [N_LANES-1:0][QUOT_W-1:0] n_s8_num;
    t_side                     n_s8_side;
    logic [N_LANES-1:0][QUOT_W-1:0] quot;
    logic [ROOT_W-1:0]         root;
    t_out_item                 n_out_item;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_dims <= 2'd2;
        end else if (i_cfg_we) begin
            r_space_dims <= i_cfg_wdata;
        end
    end

    // Stage 1: decode the point and dimension, multiply each coordinate.
    always_comb begin
        coord[0][0] = i_in_item.node0_x;
        coord[0][1] = i_in_item.node0_y;
        coord[0][2] = i_in_item.node0_z;
        coord[1][0] = i_in_item.node1_x;
        coord[1][1] = i_in_item.node1_y;
        coord[1][2] = i_in_item.node1_z;
        coord[2][0] = i_in_item.mid_x;
        coord[2][1] = i_in_item.mid_y;
        coord[2][2] = i_in_item.mid_z;
        n_meta[0]      = '0;
        n_meta[0].sel  = (i_in_item.point_select > PT_NODE_MID) ? PT_NODE_MID
                                                               : i_in_item.point_select;
        n_meta[0].dims = (r_space_dims == '0) ? DIMS_W'(1) : r_space_dims;
        for (int i = 0; i < N_NODES; i++) begin
            for (int c = 0; c < N_AXES; c++) begin
                if (DIMS_W'(c) < n_meta[0].dims) begin
                    n_s1_prod[i][c] = PROD_W'(dn_const(n_meta[0].sel, 2'(i)))
                                    * PROD_W'(coord[i][c]);
                end else begin
                    n_s1_prod[i][c] = '0;
                end
            end
        end
    end

    // Stage 2: tangent sums.
    always_comb begin
        n_meta[1] = r_meta[0];
        for (int c = 0; c < N_AXES; c++) begin
            n_s2_jt[c] = JT_W'(r_s1_prod[0][c]) + JT_W'(r_s1_prod[1][c])
                       + JT_W'(r_s1_prod[2][c]);
        end
    end

    // Stage 3: magnitudes, signs and the zero-Jacobian flag.
    always_comb begin
        n_meta[2] = r_meta[1];
        for (int c = 0; c < N_AXES; c++) begin
            n_s3_mg[c]          = r_s2_jt[c][JT_W-1] ? MAG_W'(-r_s2_jt[c]) : MAG_W'(r_s2_jt[c]);
            n_meta[2].jneg[c]   = r_s2_jt[c][JT_W-1];
        end
        n_meta[2].zero = (r_s2_jt[0] == '0) && (r_s2_jt[1] == '0) && (r_s2_jt[2] == '0);
    end

    // Stage 4: normalizing shift from the leading one, and the 1D determinant.
    always_comb begin
        n_meta[3] = r_meta[2];
        or_mag    = r_s3_mg[0] | r_s3_mg[1] | r_s3_mg[2];
        msb_pos   = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (or_mag[b]) begin
                msb_pos = POS_W'(b);
            end
        end
        n_meta[3].k   = (msb_pos > NORM_TOP) ? SHIFT_W'(msb_pos - NORM_TOP) : '0;
        n_meta[3].dm1 = DM_W'(({1'b0, r_s3_mg[0]} + LF_HALF) >> LOCAL_FRAC);
    end

    // Stage 5: shift the tangent magnitudes into range.
    always_comb begin
        n_meta[4] = r_meta[3];
        for (int c = 0; c < N_AXES; c++) begin
            n_s5_m[c] = NORM_W'(r_s4_mg[c] >> r_meta[3].k);
        end
    end

    // Stage 6: squares and derivative numerators.
    always_comb begin
        n_meta[5] = r_meta[4];
        for (int c = 0; c < N_AXES; c++) begin
            n_s6_sq[c] = SQ_W'(r_s5_m[c]) * SQ_W'(r_s5_m[c]);
            for (int i = 0; i < N_NODES; i++) begin
                n_s6_p[c * N_NODES + i] = SQ_W'(dn_mag(r_meta[4].sel, 2'(i)))
                                        * SQ_W'(r_s5_m[c]);
            end
        end
    end

    // Stage 7: squared length.
    always_comb begin
        n_meta[6] = r_meta[5];
        n_s7_s    = SUM_W'(r_s6_sq[0]) + SUM_W'(r_s6_sq[1]) + SUM_W'(r_s6_sq[2]);
    end

    // Stage 8: scale the numerators, catch quotient overflow, seed the divider.
    always_comb begin
        logic [POS_W-1:0] sh;
        logic [NUM_W-1:0] num;
        logic [NUM_W-QUOT_W-1:0] hi;
        n_meta[7]          = r_meta[6];
        sh                 = DIV_SHIFT - POS_W'(r_meta[6].k);
        n_s8_side          = '0;
        n_s8_side.zero     = r_meta[6].zero;
        n_s8_side.dims     = r_meta[6].dims;
        n_s8_side.k        = r_meta[6].k;
        n_s8_side.neg0     = r_meta[6].jneg[0];
        n_s8_side.dm1      = r_meta[6].dm1;
        for (int c = 0; c < N_AXES; c++) begin
            for (int i = 0; i < N_NODES; i++) begin
                num = NUM_W'(r_s7_p[c * N_NODES + i]) << sh;
                hi  = num[NUM_W-1:QUOT_W];
                n_s8_side.lane_nz[c * N_NODES + i]  = r_s7_p[c * N_NODES + i] != '0;
                n_s8_side.lane_ovf[c * N_NODES + i] = SUM_W'(hi) >= r_s7_s;
                n_s8_side.lane_neg[c * N_NODES + i] =
                    dn_const(r_meta[6].sel, 2'(i))[DN_W-1] ^ r_meta[6].jneg[c];
                n_s8_rem[c * N_NODES + i] = SUM_W'(hi);
                n_s8_num[c * N_NODES + i] = num[QUOT_W-1:0];
            end
        end
    end

    // Front pipeline registers: valid bits reset, payload does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 8; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < 8; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < 8; s++) begin
                r_meta[s] <= n_meta[s];
            end
            r_s1_prod <= n_s1_prod;
            r_s2_jt   <= n_s2_jt;
            r_s3_mg   <= n_s3_mg;
            r_s4_mg   <= r_s3_mg;
            r_s5_m    <= n_s5_m;
            r_s6_sq   <= n_s6_sq;
            r_s6_p    <= n_s6_p;
            r_s7_s    <= n_s7_s;
            r_s7_p    <= r_s6_p;
            r_s8_s    <= r_s7_s;
            r_s8_rem  <= n_s8_rem;
            r_s8_num  <= n_s8_num;
            r_s8_side <= n_s8_side;
        end
    end

    qbsd_div_bank u_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_den  (r_s8_s),
        .i_rem  (r_s8_rem),
        .i_num  (r_s8_num),
        .o_quot (quot)
    );

    qbsd_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_s8_s),
        .o_root (root)
    );

    // Side-band control that travels beside the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (adv) begin
            r_dv[0] <= r_vld[7];
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dside[0] <= r_s8_side;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dside[j] <= r_dside[j-1];
            end
        end
    end

    // Final stage: round the determinant and quotients, saturate, set status.
    always_comb begin
        t_side                     sd;
        t_sat_val                  det;
        t_sat_val                  lane;
        logic [SUM_W:0]            det_wide;
        logic [DM_W-1:0]           qmag;
        logic signed [COORD_W-1:0] dval [N_LANES];
        logic                      sat;
        sd       = r_dside[DIV_STEPS-1];
        sat      = 1'b0;
        det_wide = ((SUM_W + 1)'(root) << sd.k) + DET_HALF;
        if (sd.dims == DIMS_W'(1)) begin
            det = put_signed(sd.neg0, sd.dm1);
        end else begin
            det = put_signed(1'b0, DM_W'(det_wide >> LOCAL_FRAC));
        end
        sat = det.sat;
        for (int l = 0; l < N_LANES; l++) begin
            qmag = DM_W'(((DM_W + 1)'(quot[l]) + (DM_W + 1)'(1)) >> 1);
            lane = put_signed(sd.lane_neg[l], sd.lane_ovf[l] ? BIG_MAG : qmag);
            if (sd.lane_nz[l]) begin
                dval[l] = lane.val;
                sat     = sat | lane.sat;
            end else begin
                dval[l] = '0;
            end
        end
        n_out_item = '0;
        if (sd.zero) begin
            n_out_item.status = ST_ZERO;
        end else begin
            n_out_item.jac_det  = det.val;
            n_out_item.dx_node0 = dval[0];
            n_out_item.dx_node1 = dval[1];
            n_out_item.dx_mid   = dval[2];
            n_out_item.dy_node0 = dval[3];
            n_out_item.dy_node1 = dval[4];
            n_out_item.dy_mid   = dval[5];
            n_out_item.dz_node0 = dval[6];
            n_out_item.dz_node1 = dval[7];
            n_out_item.dz_mid   = dval[8];
            n_out_item.status   = sat ? ST_SAT : ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_dv[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ===== tb/sv/tb_quadratic_bar_shape_derivatives.sv =====
`timescale 1ns / 1ps

module tb_quadratic_bar_shape_derivatives;
    import qbsd_pkg::*;

    // Tracks outstanding Jacobian results and checks each returned item.
    class deriv_scoreboard;
        t_out_item expected_q[$];
        int        mismatches;
        longint    dn_tab[5][3];

        function new();
            dn_tab = '{'{-289199011, -20763555, 309962566},
                       '{20763555, 289199011, -309962566},
                       '{-402653184, -134217728, 536870912},
                       '{134217728, 402653184, -536870912},
                       '{-134217728, 134217728, 0}};
            mismatches = 0;
        endfunction

        // Clamp a sign and magnitude pair into a 32-bit two's complement value.
        function logic [31:0] clamp_q16(bit neg, longint unsigned mag, inout bit sat);
            longint unsigned top;
            top = 64'd1 << 31;
            if (neg) begin
                if (mag > top) begin
                    mag = top;
                    sat = 1'b1;
                end
                return 32'(-mag);
            end
            if (mag > top - 1) begin
                mag = top - 1;
                sat = 1'b1;
            end
            return 32'(mag);
        endfunction

        // Magnitude of p * 2^e / s, rounded half up, with a cap on huge quotients.
        function longint unsigned div_round(longint unsigned p, int e, longint unsigned s,
                                            inout bit sat);
            longint unsigned q;
            longint unsigned r;
            longint unsigned cap;
            int n;
            cap = 64'd1 << 33;
            q = p / s;
            r = p % s;
            n = e + 1;
            if (n <= 0) begin
                q = (-n >= 64) ? 0 : (q >> (-n));
            end else begin
                for (int i = 0; i < n; i++) begin
                    if (q >= cap) begin
                        sat = 1'b1;
                        return cap;
                    end
                    q = q << 1;
                    r = r << 1;
                    if (r >= s) begin
                        r = r - s;
                        q = q + 1;
                    end
                end
            end
            return (q + 1) >> 1;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Computes the expected derivatives and Jacobian for one element point.
        function t_out_item predict_derivs(t_in_item it, logic [1:0] dims_reg);
            longint          crd[3][3];
            longint unsigned jt[3];
            longint unsigned mg[3];
            longint unsigned m[3];
            longint unsigned s;
            longint unsigned len;
            longint unsigned dm;
            longint unsigned dmag;
            longint unsigned p;
            logic [31:0]     lane[9];
            t_out_item       res;
            int              sel;
            int              dims;
            int              k;
            bit              sat;
            bit              neg;
            crd[0] = '{it.node0_x, it.node0_y, it.node0_z};
            crd[1] = '{it.node1_x, it.node1_y, it.node1_z};
            crd[2] = '{it.mid_x, it.mid_y, it.mid_z};
            sel = (it.point_select > 4) ? 4 : int'(it.point_select);
            dims = (dims_reg == 0) ? 1 : int'(dims_reg);
            sat = 1'b0;
            s = 0;
            k = 0;
            res = '0;
            foreach (lane[i]) lane[i] = '0;
            for (int c = 0; c < 3; c++) begin
                jt[c] = 0;
                if (c < dims)
                    for (int i = 0; i < 3; i++) jt[c] += dn_tab[sel][i] * crd[i][c];
                mg[c] = jt[c][63] ? -jt[c] : jt[c];
            end
            // A vanishing tangent gives all-zero outputs.
            if ((mg[0] | mg[1] | mg[2]) == 0) begin
                res.status = ST_ZERO;
                return res;
            end
            while (((mg[0] >> k) | (mg[1] >> k) | (mg[2] >> k)) >= (64'd1 << 30)) k++;
            for (int c = 0; c < 3; c++) begin
                m[c] = mg[c] >> k;
                s += m[c] * m[c];
            end
            // Signed dx/dr in 1D, tangent length otherwise.
            if (dims == 1) begin
                dm = (mg[0] + (64'd1 << 27)) >> 28;
                res.jac_det = clamp_q16(jt[0][63], dm, sat);
            end else begin
                len = floor_sqrt(s);
                if (k >= 28) dm = len << (k - 28);
                else dm = (len + (64'd1 << (27 - k))) >> (28 - k);
                res.jac_det = clamp_q16(1'b0, dm, sat);
            end
            for (int c = 0; c < dims; c++) begin
                for (int i = 0; i < 3; i++) begin
                    dmag = (dn_tab[sel][i] < 0) ? -dn_tab[sel][i] : dn_tab[sel][i];
                    p = dmag * m[c];
                    neg = (dn_tab[sel][i] < 0) != jt[c][63];
                    if (p != 0)
                        lane[c * 3 + i] = clamp_q16(neg, div_round(p, 32 - k, s, sat), sat);
                end
            end
            {res.dx_node0, res.dx_node1, res.dx_mid, res.dy_node0, res.dy_node1, res.dy_mid,
             res.dz_node0, res.dz_node1, res.dz_mid} = {lane[0], lane[1], lane[2], lane[3],
             lane[4], lane[5], lane[6], lane[7], lane[8]};
            res.status = sat ? ST_SAT : ST_OK;
            return res;
        endfunction

        function void note_item(t_in_item it, logic [1:0] dims_reg);
            expected_q.push_back(predict_derivs(it, dims_reg));
        endfunction

        function void check_result(t_out_item got);
            t_out_item   exp_item;
            logic [31:0] ev[11];
            logic [31:0] gv[11];
            string       names[11];
            bit          bad;
            names = '{"jac_det", "dx_node0", "dx_node1", "dx_mid", "dy_node0", "dy_node1",
                      "dy_mid", "dz_node0", "dz_node1", "dz_mid", "status"};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %p", got);
                return;
            end
            exp_item = expected_q.pop_front();
            ev = '{exp_item.jac_det, exp_item.dx_node0, exp_item.dx_node1, exp_item.dx_mid,
                   exp_item.dy_node0, exp_item.dy_node1, exp_item.dy_mid, exp_item.dz_node0,
                   exp_item.dz_node1, exp_item.dz_mid, 32'(exp_item.status)};
            gv = '{got.jac_det, got.dx_node0, got.dx_node1, got.dx_mid, got.dy_node0,
                   got.dy_node1, got.dy_mid, got.dz_node0, got.dz_node1, got.dz_mid,
                   32'(got.status)};
            bad = 1'b0;
            foreach (ev[i]) begin
                if (gv[i] !== ev[i]) begin
                    if (!bad && mismatches < 10)
                        $display("Mismatch at %0t:", $realtime);
                    if (mismatches < 10)
                        $display("  %s expected %h got %h", names[i], ev[i], gv[i]);
                    bad = 1'b1;
                end
            end
            if (bad) mismatches++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;

    deriv_scoreboard sb = new();
    logic [1:0]      cur_dims = 2'd2;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;

    quadratic_bar_shape_derivatives u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Random back-pressure on the result side.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Check every accepted result item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    function automatic t_in_item build_item(logic [31:0] x0, logic [31:0] x1, logic [31:0] xm,
                                            logic [31:0] y0, logic [31:0] y1, logic [31:0] ym,
                                            logic [31:0] z0, logic [31:0] z1, logic [31:0] zm,
                                            logic [2:0] sel);
        t_in_item it;
        it = '{x0, y0, z0, x1, y1, z1, xm, ym, zm, sel};
        return it;
    endfunction

    // Signed random value spanning roughly +/- 2^bits.
    function automatic logic [31:0] rnd_span(int bits);
        return 32'($signed($urandom) >>> (31 - bits));
    endfunction

    function automatic logic [31:0] rnd_extreme();
        logic [31:0] picks[5];
        picks = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
        return picks[$urandom_range(0, 4)];
    endfunction

    // Random element geometry: noisy well-formed bars, plus random, small, degenerate and extreme ones.
    function automatic t_in_item rnd_item();
        t_in_item    it;
        logic [31:0] a[3];
        logic [31:0] b[3];
        logic [31:0] mid[3];
        int          kind;
        kind = $urandom_range(0, 9);
        for (int c = 0; c < 3; c++) begin
            case (kind)
                0: begin
                    a[c] = $urandom; b[c] = $urandom; mid[c] = $urandom;
                end
                5: begin
                    a[c] = rnd_span(8); b[c] = rnd_span(8); mid[c] = rnd_span(8);
                end
                6: begin
                    a[c] = $urandom; b[c] = a[c]; mid[c] = a[c];
                end
                7: begin
                    a[c] = rnd_extreme(); b[c] = rnd_extreme(); mid[c] = rnd_extreme();
                end
                8, 9: begin
                    a[c] = rnd_span(30); b[c] = rnd_span(30); mid[c] = rnd_span(30);
                end
                default: begin
                    a[c] = rnd_span(24);
                    b[c] = rnd_span(24);
                    mid[c] = 32'(($signed(a[c]) + $signed(b[c])) / 2) + rnd_span(16);
                end
            endcase
        end
        it = build_item(a[0], b[0], mid[0], a[1], b[1], mid[1], a[2], b[2], mid[2],
                        3'($urandom_range(0, 7)));
        return it;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(t_in_item it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it, cur_dims);
    endtask

    // Drain the pipeline, then write space_dims.
    task automatic write_dims(logic [1:0] d);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_dims = d;
    endtask

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every selector on a simple bar, then extremes.
        write_dims(2'd1);
        for (int sel = 0; sel < 8; sel++)
            send_item(build_item(32'h0, 32'h0002_0000, 32'h0001_4000, 0, 0, 0, 0, 0, 0,
                                 3'(sel)));
        send_item(build_item(0, 0, 0, 0, 0, 0, 0, 0, 0, PT_GAUSS_NEG));
        send_item(build_item(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0,
                             PT_NODE_LO));
        send_item(build_item(32'h0, 32'h1, 32'h0, 0, 0, 0, 0, 0, 0, PT_NODE_MID));
        write_dims(2'd3);
        send_item(build_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1,
                             PT_NODE_HI));
        send_item(build_item(0, 0, 0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0, PT_GAUSS_POS));
        send_item(build_item(5, 5, 5, 7, 7, 7, 9, 9, 9, PT_GAUSS_NEG));
        send_item(build_item(32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0001_0000,
                             32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0000_8000,
                             PT_NODE_MID));
        write_dims(2'd2);
        send_item(build_item(32'h0, 32'h0003_0000, 32'h0001_8000, 32'h0, 32'h0004_0000,
                             32'h0002_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                             PT_GAUSS_POS));
        send_item(build_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 32'h0, 0, 0, 0, PT_NODE_LO));
        write_dims(2'd0);
        send_item(build_item(32'h0001_0000, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0, PT_NODE_HI));

        // Random phases across idle patterns and every register setting.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph / 4)
                0: begin send_idle_pct = 19; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_dims(2'(ph % 4));
            repeat (140) send_item(rnd_item());
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qbsd_pkg.sv
rtl/qbsd_div_bank.sv
rtl/qbsd_isqrt.sv
rtl/quadratic_bar_shape_derivatives.sv
tb/sv/tb_quadratic_bar_shape_derivatives.sv
